// ----- design/hbf_pkg.sv -----
package hbf_pkg;

   localparam int unsigned LEN_W = 24;
   localparam int unsigned SID_W = 31;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned SLOT_W = 4;

   localparam logic [BYTE_W-1:0] TYPE_HEADERS = 8'h01;
   localparam logic [BYTE_W-1:0] TYPE_CONTINUATION = 8'h09;
   localparam logic [BYTE_W-1:0] END_STRM_FLAG = 8'h01;
   localparam logic [BYTE_W-1:0] END_HDRS_FLAG = 8'h04;

   localparam logic [SLOT_W-1:0] SLOT_FIRST_HDR = 4'd0;
   localparam logic [SLOT_W-1:0] SLOT_LAST_HDR = 4'd8;
   localparam logic [SLOT_W-1:0] SLOT_BODY = 4'd9;

   typedef struct packed {
      logic              hdr;
      logic [LEN_W-1:0]  hdr_len;
      logic [BYTE_W-1:0] hdr_kind;
      logic [BYTE_W-1:0] hdr_flags;
      logic [SID_W-1:0]  hdr_sid;
      logic              hdr_ends;
      logic              body;
      logic [BYTE_W-1:0] body_byte;
      logic              body_fend;
      logic              body_bend;
      logic              body_stray;
   } hbf_plan_type;

endpackage

// ----- design/hbf_if.sv -----
interface hbf_req_if;
   import hbf_pkg::*;
   logic              valid;
   logic              ready;
   logic              start_block;
   logic [LEN_W-1:0]  block_length;
   logic [SID_W-1:0]  stream_id;
   logic              end_stream;
   logic              has_byte;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, start_block, block_length, stream_id, end_stream,
                   has_byte, data_byte, input ready);
   modport sink (input valid, start_block, block_length, stream_id, end_stream,
                 has_byte, data_byte, output ready);
endinterface

interface hbf_rsp_if;
   import hbf_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              in_header;
   logic              frame_end;
   logic              block_end;
   logic              stray_error;
   logic              last;

   modport source (output valid, out_byte, in_header, frame_end, block_end, stray_error,
                   last, input ready);
   modport sink (input valid, out_byte, in_header, frame_end, block_end, stray_error,
                 last, output ready);
endinterface

interface hbf_csr_if;
   import hbf_pkg::*;
   logic             valid;
   logic             ready;
   logic [LEN_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ----- design/http2_header_block_framer.sv -----
// Cuts a header block, given one byte per item, into HEADERS and CONTINUATION frames
// and inserts a 9-byte frame header in front of each frame. Each accepted item is
// planned against the framing state and gives 0 to 10 result items, which leave one
// per cycle, while rsp ready holds, on the single byte-wide result port from job_ff.
// With rsp ready held, an item that gives one result keeps a rate of one item per
// cycle; an item that opens a frame gives 9 header bytes, and a two-deep plan queue
// holds the input back while those bytes drain. The user must write max_frame_size
// through the csr port while idle (not enforced); zero selects DEFAULT_MAX_FRAME.
module http2_header_block_framer
   import hbf_pkg::*;
#(
   parameter int unsigned DEFAULT_MAX_FRAME = 16384
) (
   input  logic      clock,
   input  logic      reset,
   hbf_req_if.sink   req_if,
   hbf_rsp_if.source rsp_if,
   hbf_csr_if.sink   csr_if
);

   logic [LEN_W-1:0] max_frame_ff;
   logic [LEN_W-1:0] block_left_ff, block_left_in;
   logic [LEN_W-1:0] frame_left_ff, frame_left_in;
   logic             first_frame_ff, first_frame_in;
   logic [SID_W-1:0] stream_ff, stream_in;
   logic             end_stream_ff, end_stream_in;
   logic             in_block_ff, in_block_in;

   hbf_plan_type     plan;
   hbf_plan_type     job_ff, job_in;
   hbf_plan_type     pend_ff, pend_in;
   logic             job_valid_ff, job_valid_in;
   logic             pend_valid_ff, pend_valid_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;

   logic             req_take;
   logic             plan_any;
   logic             rsp_last;
   logic             job_done;
   logic             job_free;
   logic [LEN_W-1:0] cap;
   logic [LEN_W-1:0] chunk;

   assign csr_if.ready = 1'b1;
   assign req_if.ready = !pend_valid_ff;
   assign req_take = req_if.valid && req_if.ready;

   // plan one item against the framing state
   always_comb begin
      block_left_in = block_left_ff;
      frame_left_in = frame_left_ff;
      first_frame_in = first_frame_ff;
      stream_in = stream_ff;
      end_stream_in = end_stream_ff;
      in_block_in = in_block_ff;
      plan = '0;
      cap = (max_frame_ff != '0) ? max_frame_ff : LEN_W'(DEFAULT_MAX_FRAME);
      chunk = '0;

      if (req_if.start_block) begin
         block_left_in = req_if.block_length;
         stream_in = req_if.stream_id;
         end_stream_in = req_if.end_stream;
         frame_left_in = '0;
         first_frame_in = 1'b1;
         if (req_if.block_length == '0) begin
            plan.hdr = 1'b1;
            plan.hdr_len = '0;
            plan.hdr_kind = TYPE_HEADERS;
            plan.hdr_flags = END_HDRS_FLAG | (req_if.end_stream ? END_STRM_FLAG : '0);
            plan.hdr_sid = req_if.stream_id;
            plan.hdr_ends = 1'b1;
            first_frame_in = 1'b0;
            in_block_in = 1'b0;
         end else begin
            in_block_in = 1'b1;
         end
      end

      if (req_if.has_byte) begin
         plan.body = 1'b1;
         if (!in_block_in) begin
            plan.body_stray = 1'b1;
         end else begin
            if (frame_left_in == '0) begin
               chunk = (block_left_in < cap) ? block_left_in : cap;
               plan.hdr = 1'b1;
               plan.hdr_len = chunk;
               plan.hdr_kind = first_frame_in ? TYPE_HEADERS : TYPE_CONTINUATION;
               plan.hdr_flags = ((chunk == block_left_in) ? END_HDRS_FLAG : '0)
                              | ((first_frame_in && end_stream_in) ? END_STRM_FLAG : '0);
               plan.hdr_sid = stream_in;
               plan.hdr_ends = 1'b0;
               first_frame_in = 1'b0;
               frame_left_in = chunk;
            end
            frame_left_in = frame_left_in - LEN_W'(1);
            block_left_in = block_left_in - LEN_W'(1);
            plan.body_byte = req_if.data_byte;
            plan.body_fend = (frame_left_in == '0);
            plan.body_bend = (block_left_in == '0);
            if (block_left_in == '0) begin
               in_block_in = 1'b0;
               frame_left_in = '0;
            end
         end
      end
      plan_any = plan.hdr || plan.body;
   end

   // result byte select
   always_comb begin
      rsp_if.out_byte = '0;
      rsp_if.in_header = 1'b0;
      rsp_if.frame_end = 1'b0;
      rsp_if.block_end = 1'b0;
      rsp_if.stray_error = 1'b0;
      case (slot_ff)
         4'd0: rsp_if.out_byte = job_ff.hdr_len[23:16];
         4'd1: rsp_if.out_byte = job_ff.hdr_len[15:8];
         4'd2: rsp_if.out_byte = job_ff.hdr_len[7:0];
         4'd3: rsp_if.out_byte = job_ff.hdr_kind;
         4'd4: rsp_if.out_byte = job_ff.hdr_flags;
         4'd5: rsp_if.out_byte = {1'b0, job_ff.hdr_sid[30:24]};
         4'd6: rsp_if.out_byte = job_ff.hdr_sid[23:16];
         4'd7: rsp_if.out_byte = job_ff.hdr_sid[15:8];
         4'd8: rsp_if.out_byte = job_ff.hdr_sid[7:0];
         4'd9: rsp_if.out_byte = job_ff.body_stray ? '0 : job_ff.body_byte;
         default: rsp_if.out_byte = '0;
      endcase
      if (slot_ff == SLOT_BODY) begin
         rsp_if.frame_end = job_ff.body_fend && !job_ff.body_stray;
         rsp_if.block_end = job_ff.body_bend && !job_ff.body_stray;
         rsp_if.stray_error = job_ff.body_stray;
      end else begin
         rsp_if.in_header = 1'b1;
         rsp_if.frame_end = (slot_ff == SLOT_LAST_HDR) && job_ff.hdr_ends;
         rsp_if.block_end = (slot_ff == SLOT_LAST_HDR) && job_ff.hdr_ends;
      end
   end

   assign rsp_last = (slot_ff == SLOT_BODY) || ((slot_ff == SLOT_LAST_HDR) && !job_ff.body);
   assign rsp_if.last = rsp_last;
   assign rsp_if.valid = job_valid_ff;
   assign job_done = job_valid_ff && rsp_if.ready && rsp_last;
   assign job_free = !job_valid_ff || job_done;

   // advance the plan queue
   always_comb begin
      job_in = job_ff;
      pend_in = pend_ff;
      job_valid_in = job_valid_ff;
      pend_valid_in = pend_valid_ff;
      slot_in = slot_ff;
      if (job_valid_ff && rsp_if.ready && !rsp_last) begin
         slot_in = (slot_ff == SLOT_LAST_HDR) ? SLOT_BODY : slot_ff + SLOT_W'(1);
      end
      if (job_free) begin
         job_valid_in = 1'b0;
         if (pend_valid_ff) begin
            job_in = pend_ff;
            job_valid_in = 1'b1;
            pend_valid_in = 1'b0;
            slot_in = pend_ff.hdr ? SLOT_FIRST_HDR : SLOT_BODY;
         end else if (req_take && plan_any) begin
            job_in = plan;
            job_valid_in = 1'b1;
            slot_in = plan.hdr ? SLOT_FIRST_HDR : SLOT_BODY;
         end
      end else if (req_take && plan_any) begin
         pend_in = plan;
         pend_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_ff <= '0;
         block_left_ff <= '0;
         frame_left_ff <= '0;
         first_frame_ff <= 1'b1;
         stream_ff <= '0;
         end_stream_ff <= 1'b0;
         in_block_ff <= 1'b0;
         job_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         slot_ff <= SLOT_FIRST_HDR;
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            max_frame_ff <= csr_if.data;
         end
         if (req_take) begin
            block_left_ff <= block_left_in;
            frame_left_ff <= frame_left_in;
            first_frame_ff <= first_frame_in;
            stream_ff <= stream_in;
            end_stream_ff <= end_stream_in;
            in_block_ff <= in_block_in;
         end
         job_valid_ff <= job_valid_in;
         pend_valid_ff <= pend_valid_in;
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      pend_ff <= pend_in;
   end

   a_pend_behind_job: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> job_valid_ff)
      else $error("queued plan without an active plan");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff |-> (slot_ff <= SLOT_BODY))
      else $error("result slot out of range");

   a_body_slot_needs_body: assert property (@(posedge clock) disable iff (reset)
      (job_valid_ff && (slot_ff == SLOT_BODY)) |-> job_ff.body)
      else $error("body slot reached on a header-only plan");

   a_open_block_has_bytes: assert property (@(posedge clock) disable iff (reset)
      in_block_ff |-> (block_left_ff != '0))
      else $error("open block with no bytes left");

   a_frame_inside_block: assert property (@(posedge clock) disable iff (reset)
      (frame_left_ff != '0) |-> (in_block_ff && (frame_left_ff <= block_left_ff)))
      else $error("frame count outside its block");

endmodule
